/* hw/rtl/slc_pkg.sv */
package slc_pkg;

    // Default sizes of the block.
    localparam int MAX_SPRITES_DEF  = 10;
    localparam int OAM_ENTRIES_DEF  = 40;
    localparam int SCREEN_WIDTH_DEF = 160;

    // Item operations.
    typedef enum logic [1:0] {
        OP_START_LINE = 2'd0,
        OP_OAM_ENTRY  = 2'd1,
        OP_TILE_ROW   = 2'd2,
        OP_PIXEL      = 2'd3
    } t_slc_op;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TALL_SPRITES = 2'd0;
    localparam logic [1:0] CFG_PALETTE_ZERO = 2'd1;
    localparam logic [1:0] CFG_PALETTE_ONE  = 2'd2;

    // OAM attribute bits.
    localparam int ATTR_BEHIND_BG = 7;
    localparam int ATTR_YFLIP     = 6;
    localparam int ATTR_XFLIP     = 5;
    localparam int ATTR_PALETTE   = 4;

    // Screen geometry of OAM coordinates.
    localparam logic [7:0] X_VISIBLE_MIN = 8'd1;
    localparam logic [7:0] X_VISIBLE_MAX = 8'd167;
    localparam logic [8:0] Y_OFFSET      = 9'd16;
    localparam logic [8:0] X_OFFSET      = 9'd8;
    localparam logic [3:0] VRAM_TILE_HI  = 4'h8;

    typedef struct packed {
        t_slc_op     operation;
        logic [7:0]  line;
        logic [7:0]  oam_y;
        logic [7:0]  oam_x;
        logic [7:0]  oam_tile;
        logic [7:0]  oam_attr;
        logic [5:0]  entry_index;
        logic [3:0]  slot;
        logic [7:0]  tile_low;
        logic [7:0]  tile_high;
        logic [7:0]  pixel_x;
        logic [1:0]  bg_pixel_id;
    } t_slc_in;

    typedef struct packed {
        logic        fetch_valid;
        logic [15:0] fetch_address;
        logic [3:0]  fetch_slot;
        logic        pixel_valid;
        logic        sprite_drawn;
        logic [1:0]  shade;
        logic [31:0] color_argb;
    } t_slc_out;

    // One sprite slot of the current line.
    typedef struct packed {
        logic [7:0]  x;
        logic [5:0]  index;
        logic        xflip;
        logic        under_bg;
        logic        palette_one;
        logic [15:0] row_bits;
    } t_slc_slot;

    // Tile-row fetch request from the slot file.
    typedef struct packed {
        logic        valid;
        logic [15:0] address;
        logic [3:0]  slot;
    } t_slc_fetch;

    function automatic logic [31:0] grey_of(input logic [1:0] shade);
        logic [31:0] argb;
        case (shade)
            2'd0:    argb = 32'hFFFF_FFFF;
            2'd1:    argb = 32'hFFAA_AAAA;
            2'd2:    argb = 32'hFF55_5555;
            default: argb = 32'hFF00_0000;
        endcase
        return argb;
    endfunction

endpackage

/* hw/rtl/slc_slot_file.sv */
module slc_slot_file #(
    parameter int MAX_SPRITES_PER_LINE = slc_pkg::MAX_SPRITES_DEF,
    parameter int OAM_ENTRIES          = slc_pkg::OAM_ENTRIES_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    input  slc_pkg::t_slc_in                             i_item,
    input  logic                                         i_tall,
    output slc_pkg::t_slc_slot [MAX_SPRITES_PER_LINE-1:0] o_slots,
    output logic [MAX_SPRITES_PER_LINE-1:0]              o_slot_used,
    output slc_pkg::t_slc_fetch                          o_fetch
);
    import slc_pkg::*;

    localparam int CW = $clog2(MAX_SPRITES_PER_LINE + 1);

    logic [7:0]    r_line;
    logic [CW-1:0] r_count;
    t_slc_slot     r_slots [MAX_SPRITES_PER_LINE];

    logic [4:0] height;
    logic [8:0] top;
    logic [8:0] rel;
    logic [3:0] eff;
    logic [7:0] base;
    logic [7:0] tnum;
    logic       x_ok;
    logic       on_line;
    logic       take;

    always_comb begin
        height  = i_tall ? 5'd16 : 5'd8;
        top     = {1'b0, r_line} + Y_OFFSET;
        rel     = top - {1'b0, i_item.oam_y};
        x_ok    = (i_item.oam_x >= X_VISIBLE_MIN) && (i_item.oam_x <= X_VISIBLE_MAX);
        on_line = (top >= {1'b0, i_item.oam_y}) && (rel < {4'b0, height});
        eff     = i_item.oam_attr[ATTR_YFLIP] ? (4'(height - 5'd1) - rel[3:0]) : rel[3:0];
        base    = i_tall ? {i_item.oam_tile[7:1], 1'b0} : i_item.oam_tile;
        tnum    = base + {7'b0, eff[3]};
        take    = i_valid && (i_item.operation == OP_OAM_ENTRY)
                  && (r_count < CW'(MAX_SPRITES_PER_LINE))
                  && ({1'b0, i_item.entry_index} < 7'(OAM_ENTRIES))
                  && x_ok && on_line;

        o_fetch.valid   = take;
        o_fetch.address = {VRAM_TILE_HI, tnum, eff[2:0], 1'b0};
        o_fetch.slot    = 4'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= '0;
            r_count <= '0;
        end else if (i_valid && (i_item.operation == OP_START_LINE)) begin
            r_line  <= i_item.line;
            r_count <= '0;
        end else if (take) begin
            r_count <= r_count + CW'(1);
        end
    end

    for (genvar s = 0; s < MAX_SPRITES_PER_LINE; s++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (take && (r_count == CW'(s))) begin
                r_slots[s].x           <= i_item.oam_x;
                r_slots[s].index       <= i_item.entry_index;
                r_slots[s].xflip       <= i_item.oam_attr[ATTR_XFLIP];
                r_slots[s].under_bg    <= i_item.oam_attr[ATTR_BEHIND_BG];
                r_slots[s].palette_one <= i_item.oam_attr[ATTR_PALETTE];
                r_slots[s].row_bits    <= '0;
            end else if (i_valid && (i_item.operation == OP_TILE_ROW)
                         && (i_item.slot == 4'(s)) && (CW'(s) < r_count)) begin
                r_slots[s].row_bits <= {i_item.tile_high, i_item.tile_low};
            end
        end

        assign o_slots[s]     = r_slots[s];
        assign o_slot_used[s] = (CW'(s) < r_count);
    end

endmodule

/* hw/rtl/slc_pixel_mixer.sv */
module slc_pixel_mixer #(
    parameter int MAX_SPRITES_PER_LINE = slc_pkg::MAX_SPRITES_DEF,
    parameter int SCREEN_WIDTH         = slc_pkg::SCREEN_WIDTH_DEF
) (
    input  slc_pkg::t_slc_slot [MAX_SPRITES_PER_LINE-1:0] i_slots,
    input  logic [MAX_SPRITES_PER_LINE-1:0]               i_slot_used,
    input  logic [7:0]                                    i_pixel_x,
    input  logic [1:0]                                    i_bg_id,
    input  logic [7:0]                                    i_palette_zero,
    input  logic [7:0]                                    i_palette_one,
    output logic                                          o_drawn,
    output logic [1:0]                                    o_shade
);
    import slc_pkg::*;

    localparam int N = MAX_SPRITES_PER_LINE;

    logic [8:0]        pos;
    logic [N-1:0]      cand;
    logic [N-1:0][1:0] slot_shade;
    logic [N-1:0]      win;
    logic [1:0]        shade_or;
    logic              on_screen;

    assign pos       = {1'b0, i_pixel_x} + X_OFFSET;
    assign on_screen = ({1'b0, i_pixel_x} < 9'(SCREEN_WIDTH));

    // Each slot decides on its own whether it covers the column with a visible pixel.
    for (genvar s = 0; s < N; s++) begin : g_lane
        logic [8:0] col_off;
        logic [2:0] bitsel;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [1:0] id;
        logic [7:0] pal;

        assign col_off = pos - {1'b0, i_slots[s].x};
        assign bitsel  = ~(col_off[2:0] ^ {3{i_slots[s].xflip}});
        assign lo      = i_slots[s].row_bits[7:0];
        assign hi      = i_slots[s].row_bits[15:8];
        assign id      = {hi[bitsel], lo[bitsel]};
        assign pal     = i_slots[s].palette_one ? i_palette_one : i_palette_zero;
        assign cand[s] = i_slot_used[s] && (pos >= {1'b0, i_slots[s].x}) && (col_off < 9'd8)
                         && (id != 2'd0) && !(i_slots[s].under_bg && (i_bg_id != 2'd0));
        assign slot_shade[s] = pal[{id, 1'b0} +: 2];
    end

    // A candidate wins when no other candidate beats it: smaller X, then
    // smaller OAM index, then lower slot. All pairs are compared in parallel.
    always_comb begin
        win = cand;
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                if (j != i && cand[j]) begin
                    if ((i_slots[j].x < i_slots[i].x)
                        || ((i_slots[j].x == i_slots[i].x)
                            && ((i_slots[j].index < i_slots[i].index)
                                || ((i_slots[j].index == i_slots[i].index) && (j < i))))) begin
                        win[i] = 1'b0;
                    end
                end
            end
        end
        shade_or = 2'd0;
        for (int i = 0; i < N; i++) begin
            if (win[i]) begin
                shade_or = shade_or | slot_shade[i];
            end
        end
    end

    assign o_drawn = on_screen && (|win);
    assign o_shade = o_drawn ? shade_or : 2'd0;

endmodule

/* hw/rtl/sprite_line_compositor.sv */
// Channel        Direction  Handshake                  Payload
// item           in         start high, busy low       i_item (t_slc_in)
// result         out        o_result_valid, one cycle  o_result (t_slc_out)
// configuration  in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One transaction can be taken in every clock cycle; busy is always low.
// A result is registered: its item passes the input register and then the
// result register, and the slot file and the parallel mixer lanes fit
// between the two.
// Reset is synchronous and active low; it clears the line, the slot count,
// the configuration registers and the valid flags of both registers.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module sprite_line_compositor #(
    parameter int MAX_SPRITES_PER_LINE = slc_pkg::MAX_SPRITES_DEF,
    parameter int OAM_ENTRIES          = slc_pkg::OAM_ENTRIES_DEF,
    parameter int SCREEN_WIDTH         = slc_pkg::SCREEN_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  slc_pkg::t_slc_in  i_item,
    output logic              o_result_valid,
    output slc_pkg::t_slc_out o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import slc_pkg::*;

    // Configuration registers.
    logic       r_tall;
    logic [7:0] r_palette_zero;
    logic [7:0] r_palette_one;

    // Input register.
    logic    r_in_valid;
    t_slc_in r_in;

    // Result register.
    logic     r_out_valid;
    t_slc_out r_out;
    logic     n_out_valid;
    t_slc_out n_out;

    t_slc_slot [MAX_SPRITES_PER_LINE-1:0] slots;
    logic [MAX_SPRITES_PER_LINE-1:0]      slot_used;
    t_slc_fetch                           fetch;
    logic                                 drawn;
    logic [1:0]                           shade;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tall         <= 1'b0;
            r_palette_zero <= '0;
            r_palette_one  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TALL_SPRITES: r_tall         <= i_cfg_data[0];
                CFG_PALETTE_ZERO: r_palette_zero <= i_cfg_data;
                CFG_PALETTE_ONE:  r_palette_one  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    // The slot file updates the line state at the end of the cycle in which
    // the item sits in the input register, so the next item sees it at once.
    slc_slot_file #(
        .MAX_SPRITES_PER_LINE (MAX_SPRITES_PER_LINE),
        .OAM_ENTRIES          (OAM_ENTRIES)
    ) u_slot_file (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_item      (r_in),
        .i_tall      (r_tall),
        .o_slots     (slots),
        .o_slot_used (slot_used),
        .o_fetch     (fetch)
    );

    slc_pixel_mixer #(
        .MAX_SPRITES_PER_LINE (MAX_SPRITES_PER_LINE),
        .SCREEN_WIDTH         (SCREEN_WIDTH)
    ) u_mixer (
        .i_slots        (slots),
        .i_slot_used    (slot_used),
        .i_pixel_x      (r_in.pixel_x),
        .i_bg_id        (r_in.bg_pixel_id),
        .i_palette_zero (r_palette_zero),
        .i_palette_one  (r_palette_one),
        .o_drawn        (drawn),
        .o_shade        (shade)
    );

    // Start-line and tile-row items give no result; an OAM entry gives one
    // only when it takes a slot; a pixel request always answers.
    always_comb begin
        n_out       = '0;
        n_out_valid = 1'b0;
        if (fetch.valid) begin
            n_out_valid         = 1'b1;
            n_out.fetch_valid   = 1'b1;
            n_out.fetch_address = fetch.address;
            n_out.fetch_slot    = fetch.slot;
        end else if (r_in_valid && (r_in.operation == OP_PIXEL)) begin
            n_out_valid        = 1'b1;
            n_out.pixel_valid  = 1'b1;
            n_out.sprite_drawn = drawn;
            n_out.shade        = shade;
            n_out.color_argb   = drawn ? grey_of(shade) : 32'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

/* bench/sprite_line_compositor_tb.sv */
`timescale 1ns / 100ps

module sprite_line_compositor_tb;
    import slc_pkg::*;

    // Sizes of the block as instantiated with its defaults.
    localparam int LANES       = MAX_SPRITES_DEF;
    localparam int OAM_COUNT   = OAM_ENTRIES_DEF;
    localparam int COLUMNS     = SCREEN_WIDTH_DEF;
    // Margin after the last owed answer arrives; it covers entries and rows
    // that answer nothing.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_GUARD   = 1000;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_slc_in     i_item = '0;
    logic        o_result_valid;
    t_slc_out    o_result;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_TALL_SPRITES;
    logic [7:0]  i_cfg_data = 8'd0;

    sprite_line_compositor uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the block's registers and of the sprite slots of the
    // current scanline. They advance at the edge that accepts each transaction.
    logic       tall_mode = 1'b0;
    logic [7:0] obj_pal0 = 8'd0;
    logic [7:0] obj_pal1 = 8'd0;
    logic [7:0] line_now = 8'd0;
    int         lanes_used = 0;
    t_slc_slot  lane [LANES];

    // Fetch requests and pixel answers still owed by the block, oldest first.
    t_slc_out   answers_due [$];
    int         mismatches = 0;
    int         items_sent = 0;
    bit         gaps_on = 1'b0;

    function automatic logic [31:0] argb_of(input logic [1:0] tone);
        case (tone)
            2'd0:    return 32'hFFFF_FFFF;
            2'd1:    return 32'hFFAA_AAAA;
            2'd2:    return 32'hFF55_5555;
            default: return 32'hFF00_0000;
        endcase
    endfunction

    // Applies one transaction to our copy of the line state. Returns 1 when the
    // block owes a result for it, and that result in res.
    function automatic logic composite_item(input t_slc_in it, output t_slc_out res);
        logic       produced;
        int         height, top, ypos, xpos, rel, eff, pos, col, bitn, s, best_x;
        logic [7:0] tile_base, tile_num, best_pal;
        logic [5:0] best_idx;
        logic [1:0] id, best_id;
        logic       found;
        res = '0;
        produced = 1'b0;
        case (it.operation)
            OP_START_LINE: begin
                line_now = it.line;
                lanes_used = 0;
            end
            OP_OAM_ENTRY: begin
                height = tall_mode ? 16 : 8;
                top = int'(line_now) + int'(Y_OFFSET);
                ypos = int'(it.oam_y);
                rel = top - ypos;
                if (lanes_used < LANES && int'(it.entry_index) < OAM_COUNT &&
                    it.oam_x >= X_VISIBLE_MIN && it.oam_x <= X_VISIBLE_MAX &&
                    rel >= 0 && rel < height) begin
                    // Y-flip mirrors the row over the full height, so in tall
                    // mode it also swaps the two tiles of the pair.
                    eff = it.oam_attr[ATTR_YFLIP] ? height - 1 - rel : rel;
                    tile_base = tall_mode ? {it.oam_tile[7:1], 1'b0} : it.oam_tile;
                    tile_num = tile_base + 8'(eff / 8);
                    res.fetch_valid = 1'b1;
                    res.fetch_address = {VRAM_TILE_HI, 12'h000} + {4'h0, tile_num, 4'h0}
                                        + 16'((eff % 8) * 2);
                    res.fetch_slot = 4'(lanes_used);
                    lane[lanes_used].x = it.oam_x;
                    lane[lanes_used].index = it.entry_index;
                    lane[lanes_used].xflip = it.oam_attr[ATTR_XFLIP];
                    lane[lanes_used].under_bg = it.oam_attr[ATTR_BEHIND_BG];
                    lane[lanes_used].palette_one = it.oam_attr[ATTR_PALETTE];
                    lane[lanes_used].row_bits = 16'd0;
                    lanes_used++;
                    produced = 1'b1;
                end
            end
            OP_TILE_ROW: begin
                if (int'(it.slot) < lanes_used)
                    lane[it.slot].row_bits = {it.tile_high, it.tile_low};
            end
            OP_PIXEL: begin
                produced = 1'b1;
                res.pixel_valid = 1'b1;
                found = 1'b0;
                best_x = 0;
                best_idx = '0;
                best_id = '0;
                best_pal = '0;
                if (int'(it.pixel_x) < COLUMNS) begin
                    pos = int'(it.pixel_x) + int'(X_OFFSET);
                    for (s = 0; s < lanes_used; s++) begin
                        xpos = int'(lane[s].x);
                        if (pos >= xpos && pos - xpos < 8) begin
                            col = pos - xpos;
                            if (lane[s].xflip)
                                col = 7 - col;
                            bitn = 7 - col;
                            id = {lane[s].row_bits[bitn + 8], lane[s].row_bits[bitn]};
                            // Strict compares keep the lower slot on a full tie.
                            if (id != 2'd0 &&
                                !(lane[s].under_bg && it.bg_pixel_id != 2'd0) &&
                                (!found || xpos < best_x ||
                                 (xpos == best_x && lane[s].index < best_idx))) begin
                                found = 1'b1;
                                best_x = xpos;
                                best_idx = lane[s].index;
                                best_id = id;
                                best_pal = lane[s].palette_one ? obj_pal1 : obj_pal0;
                            end
                        end
                    end
                end
                if (found) begin
                    res.sprite_drawn = 1'b1;
                    res.shade = 2'(best_pal >> {best_id, 1'b0});
                    res.color_argb = argb_of(res.shade);
                end
            end
        endcase
        return produced;
    endfunction

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
    endtask

    // Every result is shown for one cycle only, so it is taken at the edge that
    // ends that cycle and matched against the oldest owed answer.
    always @(posedge i_clk) begin : result_check
        t_slc_out want;
        if (o_result_valid === 1'b1) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", o_result);
            end else begin
                want = answers_due.pop_front();
                report_field("fetch_valid", 32'(want.fetch_valid),
                             32'(o_result.fetch_valid));
                report_field("fetch_address", 32'(want.fetch_address),
                             32'(o_result.fetch_address));
                report_field("fetch_slot", 32'(want.fetch_slot), 32'(o_result.fetch_slot));
                report_field("pixel_valid", 32'(want.pixel_valid),
                             32'(o_result.pixel_valid));
                report_field("sprite_drawn", 32'(want.sprite_drawn),
                             32'(o_result.sprite_drawn));
                report_field("shade", 32'(want.shade), 32'(o_result.shade));
                report_field("color_argb", want.color_argb, o_result.color_argb);
            end
        end
    end

    // Fields that an operation does not use still carry random values.
    function automatic t_slc_in random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_slc_in)-1:0];
    endfunction

    function automatic t_slc_in line_start(input logic [7:0] line_no);
        t_slc_in it;
        it = random_item();
        it.operation = OP_START_LINE;
        it.line = line_no;
        return it;
    endfunction

    function automatic t_slc_in entry(input logic [7:0] y, input logic [7:0] x,
                                      input logic [7:0] tile, input logic [7:0] attr,
                                      input logic [5:0] idx);
        t_slc_in it;
        it = random_item();
        it.operation = OP_OAM_ENTRY;
        it.oam_y = y;
        it.oam_x = x;
        it.oam_tile = tile;
        it.oam_attr = attr;
        it.entry_index = idx;
        return it;
    endfunction

    function automatic t_slc_in row(input logic [3:0] slot_no, input logic [7:0] lo,
                                    input logic [7:0] hi);
        t_slc_in it;
        it = random_item();
        it.operation = OP_TILE_ROW;
        it.slot = slot_no;
        it.tile_low = lo;
        it.tile_high = hi;
        return it;
    endfunction

    function automatic t_slc_in pixel(input logic [7:0] column, input logic [1:0] bg);
        t_slc_in it;
        it = random_item();
        it.operation = OP_PIXEL;
        it.pixel_x = column;
        it.bg_pixel_id = bg;
        return it;
    endfunction

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Offers one transaction and keeps it on the port until the block takes it.
    // Start stays high on return so back-to-back transactions need no gap.
    task automatic send_item(input t_slc_in it);
        t_slc_out ans;
        if (gaps_on && $urandom_range(0, 7) == 0)
            hold_off($urandom_range(1, 15));
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        if (composite_item(it, ans))
            answers_due = {answers_due, ans};
        items_sent++;
    endtask

    // Lets every owed answer arrive, then waits out a settle margin for work that
    // answers nothing, so that the block is idle afterwards.
    task automatic wait_idle();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (answers_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_TALL_SPRITES: tall_mode = value[0];
            CFG_PALETTE_ZERO: obj_pal0 = value;
            CFG_PALETTE_ONE:  obj_pal1 = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic tall, input logic [7:0] pal0,
                                input logic [7:0] pal1);
        write_reg(CFG_TALL_SPRITES, {7'd0, tall});
        write_reg(CFG_PALETTE_ZERO, pal0);
        write_reg(CFG_PALETTE_ONE, pal1);
        i_cfg_we <= 1'b0;
    endtask

    // One 8x8 line: entries at both ends of the visible X range, rows above
    // and below the sprite, X off either edge, an index past the end of OAM,
    // all attribute flags, a row sent to a free slot, and columns off screen.
    task automatic test_small_sprites();
        send_item(line_start(8'd20));
        send_item(entry(8'd36, 8'd1, 8'hFF, 8'h00, 6'd0));
        send_item(entry(8'd30, 8'd167, 8'h03, 8'h40, 6'd1));
        send_item(entry(8'd29, 8'd50, 8'h80, 8'hB0, 6'd39));
        send_item(entry(8'd37, 8'd60, 8'h00, 8'h00, 6'd3));
        send_item(entry(8'd28, 8'd60, 8'h00, 8'h00, 6'd4));
        send_item(entry(8'd36, 8'd0, 8'h00, 8'h00, 6'd5));
        send_item(entry(8'd36, 8'd168, 8'h00, 8'h00, 6'd6));
        send_item(entry(8'd36, 8'd60, 8'h00, 8'h00, 6'd40));
        send_item(row(4'd0, 8'hAA, 8'hCC));
        send_item(row(4'd1, 8'hFF, 8'hFF));
        send_item(row(4'd2, 8'h0F, 8'hF0));
        send_item(row(4'd3, 8'hFF, 8'hFF));
        send_item(pixel(8'd0, 2'd0));
        send_item(pixel(8'd159, 2'd3));
        send_item(pixel(8'd45, 2'd1));
        send_item(pixel(8'd45, 2'd0));
        send_item(pixel(8'd160, 2'd0));
        send_item(pixel(8'd255, 2'd0));
    endtask

    // 8x16 sprites: the last line number, tile pairs with bit 0 ignored, Y-flip
    // across both halves, and priority by index and then by slot on equal X.
    task automatic test_tall_sprites();
        send_item(line_start(8'd255));
        send_item(entry(8'd255, 8'd20, 8'h00, 8'h00, 6'd0));
        send_item(line_start(8'd143));
        send_item(entry(8'd144, 8'd20, 8'h11, 8'h00, 6'd7));
        send_item(entry(8'd159, 8'd20, 8'hFF, 8'h50, 6'd2));
        send_item(entry(8'd159, 8'd20, 8'h00, 8'h00, 6'd2));
        send_item(row(4'd0, 8'hFF, 8'hFF));
        send_item(row(4'd1, 8'h0F, 8'h0F));
        send_item(row(4'd2, 8'hFF, 8'h00));
        send_item(pixel(8'd12, 2'd0));
        send_item(pixel(8'd19, 2'd2));
        send_item(pixel(8'd11, 2'd0));
    endtask

    // Well-formed scanlines with random content: a start-line transaction,
    // entries in rising index order that mostly cross the line and cluster in
    // X, rows for most taken slots, then pixels mostly under the sprites. A
    // little noise (random transactions, rows to random slots) is mixed in.
    task automatic test_random_lines(input int item_goal, input bit allow_gaps);
        t_slc_in    it;
        int         target, height, idx, count, base_x, col, s;
        logic [7:0] line_no, last_x;
        target = items_sent + item_goal;
        while (items_sent < target) begin
            gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
            line_no = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 143));
            send_item(line_start(line_no));
            height = tall_mode ? 16 : 8;
            idx = $urandom_range(0, 4);
            base_x = $urandom_range(1, 155);
            last_x = 8'(base_x);
            count = $urandom_range(3, 16);
            repeat (count) begin
                it = entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           6'(idx));
                if ($urandom_range(0, 9) < 7)
                    it.oam_y = 8'(int'(line_no) + 16 - $urandom_range(0, height - 1));
                if ($urandom_range(0, 4) == 0)
                    it.oam_x = last_x;
                else if ($urandom_range(0, 9) < 8)
                    it.oam_x = 8'(base_x + $urandom_range(0, 12));
                if ($urandom_range(0, 19) == 0)
                    it.entry_index = 6'($urandom);
                last_x = it.oam_x;
                idx += $urandom_range(1, 3);
                send_item(it);
                if ($urandom_range(0, 11) == 0)
                    send_item(random_item());
            end
            for (s = 0; s < lanes_used; s++) begin
                if ($urandom_range(0, 7) != 0)
                    send_item(row(4'(s), 8'($urandom), 8'($urandom)));
            end
            if ($urandom_range(0, 5) == 0)
                send_item(row(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom)));
            repeat ($urandom_range(8, 20)) begin
                if (lanes_used > 0 && $urandom_range(0, 7) < 6) begin
                    s = $urandom_range(0, lanes_used - 1);
                    col = int'(lane[s].x) - int'(X_OFFSET) + $urandom_range(0, 7);
                    if (col < 0)
                        col = $urandom_range(0, COLUMNS - 1);
                end else if ($urandom_range(0, 7) == 0) begin
                    col = $urandom_range(0, 255);
                end else begin
                    col = $urandom_range(0, COLUMNS - 1);
                end
                send_item(pixel(8'(col), $urandom_range(0, 1) ? 2'd0
                                                             : 2'($urandom_range(0, 3))));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_regs(1'b0, 8'hE4, 8'h1B);
        gaps_on = 1'b1;
        test_small_sprites();
        wait_idle();
        program_regs(1'b1, 8'hFF, 8'h00);
        test_tall_sprites();

        // Each random phase starts from an idle block with new register values;
        // the last phase runs without gaps so the pipeline stays full.
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            program_regs(phase[0], 8'($urandom), 8'($urandom));
            test_random_lines(115, phase != 3);
        end
        gaps_on = 1'b0;

        wait_idle();
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

/* sprite_line_compositor.f */
hw/rtl/slc_pkg.sv
hw/rtl/slc_slot_file.sv
hw/rtl/slc_pixel_mixer.sv
hw/rtl/sprite_line_compositor.sv
bench/sprite_line_compositor_tb.sv
